/* hdl/lcdw_pkg.sv */
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types, codes and the strobe sequencing function of the character
// LCD bus writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_INSTR = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] REG_BUS_MODE      = 2'd0;
  localparam logic [1:0] REG_CLOCKS_PER_US = 2'd1;

  localparam logic [9:0] CLOCKS_PER_US_RESET = 10'd72;

  // Bus timing in microseconds
  localparam logic [15:0] POWER_UP_US    = 16'd40000;
  localparam logic [15:0] ENABLE_US      = 16'd1;
  localparam logic [12:0] SETTLE_US      = 13'd40;
  localparam logic [12:0] SETTLE_SHORT_US = 13'd140;
  localparam logic [12:0] SETTLE_CLEAR_US = 13'd2040;
  localparam logic [12:0] SETTLE_FIRST_US = 13'd5040;

  // Instruction bytes with a long execution time
  localparam logic [7:0] INSTR_CLEAR = 8'h01;
  localparam logic [7:0] INSTR_HOME  = 8'h02;

  // Init prefix strobes before the first full byte
  localparam logic [3:0] PREFIX_LEN_NIBBLE = 4'd4;
  localparam logic [3:0] PREFIX_LEN_BYTE   = 4'd3;
  localparam logic [2:0] INIT_LAST_BYTE    = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  // One strobe record
  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [15:0] lead_wait_us;
    logic [12:0] settle_wait_us;
    logic        last;
  } strobe_rec_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic timer_busy;
    logic rec_last;
  } dp_stat_t;

  // Full bytes of the init sequence after the prefix
  function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic mode);
    logic [7:0] b;
    case (idx)
      3'd0:    b = mode ? 8'h30 : 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h0C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Build the record for one strobe of the current request
  function automatic strobe_rec_t strobe_rec(input cmd_e kind, input logic [7:0] val,
                                             input logic mode, input logic [3:0] step);
    strobe_rec_t r;
    logic [3:0]  pre_n;
    logic        in_pre;
    logic [3:0]  bstep;
    logic        byte_end;
    logic [2:0]  bidx;
    logic [7:0]  b;
    pre_n    = mode ? PREFIX_LEN_BYTE : PREFIX_LEN_NIBBLE;
    in_pre   = (kind == CMD_INIT) && (step < pre_n);
    bstep    = (kind == CMD_INIT) ? (step - pre_n) : step;
    byte_end = mode | bstep[0];
    bidx     = mode ? bstep[2:0] : bstep[3:1];
    b        = (kind == CMD_INIT) ? init_byte(bidx, mode) : val;

    r.reg_select = (kind == CMD_DATA);
    if (in_pre) begin
      if (mode) begin
        r.bus_value = 8'h30;
      end else begin
        r.bus_value = (step == 4'd3) ? 8'h02 : 8'h03;
      end
      r.lead_wait_us   = (step == 4'd0) ? POWER_UP_US : 16'd0;
      r.settle_wait_us = (step == 4'd0) ? SETTLE_FIRST_US :
                         (step == 4'd1) ? SETTLE_SHORT_US : SETTLE_US;
      r.last           = 1'b0;
    end else begin
      if (mode) begin
        r.bus_value = b;
      end else begin
        r.bus_value = bstep[0] ? {4'h0, b[3:0]} : {4'h0, b[7:4]};
      end
      r.lead_wait_us   = 16'd0;
      r.settle_wait_us = (byte_end && (b == INSTR_CLEAR || b == INSTR_HOME)) ?
                         SETTLE_CLEAR_US : SETTLE_US;
      r.last           = byte_end && ((kind != CMD_INIT) || (bidx == INIT_LAST_BYTE));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/char_lcd_bus_writer_core.sv */
// ----------------------------------------------------------------------------
// char_lcd_bus_writer_core
// Write-only character LCD bus controller: turns data, instruction and init
// requests into enable strobe records for a 4-bit or 8-bit parallel bus.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid_i/ready_o   | cmd_i, value_i
//   out     | out_valid_o/ready_i  | reg_select_o, read_write_o, bus_value_o,
//           |                      | lead_wait_us_o, settle_wait_us_o, last_o
//   cfg     | cfg_we_i             | cfg_index_i, cfg_data_i
//
// Each strobe record is registered once the previous strobe's bus time has
// run out and the slot is free: (lead + 1 + settle) us, counted by the
// microsecond timer. A character takes 2 strobes (about 82 us) on the 4-bit
// bus, 1 strobe on the 8-bit bus; init takes 14 or 8 strobes (about 47 ms).
// A new request is taken once the last strobe of the previous one has timed
// out, while its record may still wait in the output register.
// Reset returns to idle with the timer cleared; a stalled output holds the
// sequencer until the record is taken.
`default_nettype none

module char_lcd_bus_writer_core
  import lcdw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [9:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             reg_select_o,
  output logic             read_write_o,
  output logic [7:0]       bus_value_o,
  output logic [15:0]      lead_wait_us_o,
  output logic [12:0]      settle_wait_us_o,
  output logic             last_o
);

  dp_cmd_t     dp_cmd;
  dp_stat_t    dp_stat;
  strobe_rec_t rec;
  cmd_e        cmd;

  assign cmd = cmd_e'(cmd_i);

  lcdw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  lcdw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .cmd_ctl_i   (dp_cmd),
    .stat_o      (dp_stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .rec_o       (rec)
  );

  // Drive the record fields; the bus is write only
  assign reg_select_o     = rec.reg_select;
  assign read_write_o     = 1'b0;
  assign bus_value_o      = rec.bus_value;
  assign lead_wait_us_o   = rec.lead_wait_us;
  assign settle_wait_us_o = rec.settle_wait_us;
  assign last_o           = rec.last;

endmodule

`default_nettype wire

/* hdl/lcdw_ctrl.sv */
// ----------------------------------------------------------------------------
// lcdw_ctrl
// Sequencer of the bus writer: takes a request, then issues one strobe at a
// time whenever the output slot is free and the bus timer has expired.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_ctrl
  import lcdw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire cmd_e     cmd_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        // take a new request once the previous strobe has timed out;
        // the unused command code is taken and dropped
        in_ready_o = !stat_i.timer_busy;
        if (in_valid_i && !stat_i.timer_busy && (cmd_i != CMD_NONE)) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat_i.slot_free && !stat_i.timer_busy) begin
          cmd_o.emit = 1'b1;
          if (stat_i.rec_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/lcdw_datapath.sv */
// ----------------------------------------------------------------------------
// lcdw_datapath
// Configuration registers, held request, strobe step counter, output record
// register and the microsecond bus timer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_datapath
  import lcdw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [9:0]  cfg_data_i,
  input  wire cmd_e        cmd_i,
  input  wire logic [7:0]  value_i,
  input  wire dp_cmd_t     cmd_ctl_i,
  output dp_stat_t         stat_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output strobe_rec_t      rec_o
);

  logic        bus_mode_q;
  logic [9:0]  clocks_per_us_q;
  cmd_e        kind_q;
  logic [7:0]  byte_q;
  logic        mode_q;
  logic [3:0]  step_q;
  logic        out_valid_q;
  strobe_rec_t rec_q;
  logic [15:0] us_cnt_q;
  logic [9:0]  pre_cnt_q;
  strobe_rec_t rec_d;
  logic        us_tick;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_mode_q      <= 1'b0;
      clocks_per_us_q <= CLOCKS_PER_US_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_BUS_MODE) begin
        bus_mode_q <= cfg_data_i[0];
      end
      if (cfg_index_i == REG_CLOCKS_PER_US) begin
        clocks_per_us_q <= cfg_data_i;
      end
    end
  end

  // Hold the request and step through its strobes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= CMD_DATA;
      byte_q <= 8'h00;
      mode_q <= 1'b0;
      step_q <= 4'd0;
    end else if (cmd_ctl_i.load) begin
      kind_q <= cmd_i;
      byte_q <= value_i;
      mode_q <= bus_mode_q;
      step_q <= 4'd0;
    end else if (cmd_ctl_i.emit) begin
      step_q <= step_q + 4'd1;
    end
  end

  assign rec_d = strobe_rec(kind_q, byte_q, mode_q, step_q);

  // Output record register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.emit) begin
      rec_q <= rec_d;
    end
  end

  // Microsecond prescaler; a setting of zero ticks every cycle
  assign us_tick = ({1'b0, pre_cnt_q} + 11'd1) >= {1'b0, clocks_per_us_q};

  // Bus timer: lead wait, enable pulse and settle time of each strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      us_cnt_q  <= 16'd0;
      pre_cnt_q <= 10'd0;
    end else if (cmd_ctl_i.emit) begin
      us_cnt_q  <= rec_d.lead_wait_us + ENABLE_US + {3'b000, rec_d.settle_wait_us};
      pre_cnt_q <= 10'd0;
    end else if (us_cnt_q != 16'd0) begin
      if (us_tick) begin
        pre_cnt_q <= 10'd0;
        us_cnt_q  <= us_cnt_q - 16'd1;
      end else begin
        pre_cnt_q <= pre_cnt_q + 10'd1;
      end
    end
  end

  always_comb begin
    stat_o.slot_free  = !out_valid_q || out_ready_i;
    stat_o.timer_busy = (us_cnt_q != 16'd0);
    stat_o.rec_last   = rec_d.last;
  end

  assign out_valid_o = out_valid_q;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire

/* hdl/lcdw_checker.sv */
// ----------------------------------------------------------------------------
// lcdw_checker
// Port-level checks of the bus writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        reg_select_o,
  input wire logic        read_write_o,
  input wire logic [7:0]  bus_value_o,
  input wire logic [15:0] lead_wait_us_o,
  input wire logic [12:0] settle_wait_us_o
);

  // Stalled record holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bus_value_o))
    else $error("stalled strobe record changed");

  // Writes only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !read_write_o)
    else $error("read strobe issued");

  // Power-up wait only on the first init strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (lead_wait_us_o != 16'd0) |->
      !reg_select_o && (settle_wait_us_o == 13'd5040))
    else $error("power-up wait on a wrong strobe");

  // Settle time is one of the known values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (settle_wait_us_o == 13'd40) || (settle_wait_us_o == 13'd140) ||
                    (settle_wait_us_o == 13'd2040) || (settle_wait_us_o == 13'd5040))
    else $error("unknown settle time");

endmodule

bind char_lcd_bus_writer_core lcdw_checker u_lcdw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .reg_select_o     (reg_select_o),
  .read_write_o     (read_write_o),
  .bus_value_o      (bus_value_o),
  .lead_wait_us_o   (lead_wait_us_o),
  .settle_wait_us_o (settle_wait_us_o)
);

`default_nettype wire

/* dv/tb_char_lcd_bus_writer_core.sv */
// ----------------------------------------------------------------------------
// tb_char_lcd_bus_writer_core
// Self-checking bench for the character LCD bus writer. Sends data,
// instruction, init and unused requests over both bus widths and several
// clock scalings. Every accepted request is turned into its expected strobe
// records, and each record that leaves the block is checked against them in
// order. The sender works in bursts and the receiver stalls on a rotating
// pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_char_lcd_bus_writer_core;
  import lcdw_pkg::*;

  // Register indexes past the end of the register list
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  // Instruction bytes sent by the init sequence
  localparam logic [7:0] FUNC_SET_8BIT = 8'h30;
  localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
  localparam logic [7:0] DISPLAY_OFF   = 8'h08;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;
  localparam logic [7:0] DISPLAY_ON    = 8'h0C;
  localparam logic [7:0] WAKE_BYTE     = 8'h30;
  localparam logic [7:0] WAKE_NIBBLE   = 8'h03;
  localparam logic [7:0] NIBBLE_SWITCH = 8'h02;

  localparam int IDLE_WAIT_LIMIT = 600000;

  typedef struct {
    logic        reg_select;
    logic        read_write;
    logic [7:0]  bus_value;
    logic [15:0] lead_wait_us;
    logic [12:0] settle_wait_us;
    logic        last;
  } strobe_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [9:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i       = '0;
  logic [7:0]  value_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        reg_select_o;
  logic        read_write_o;
  logic [7:0]  bus_value_o;
  logic [15:0] lead_wait_us_o;
  logic [12:0] settle_wait_us_o;
  logic        last_o;

  // Shadow of the configuration and the expected strobe records
  logic        byte_bus   = 1'b0;
  logic [9:0]  clocks_cfg = CLOCKS_PER_US_RESET;
  strobe_t     pending_strobes[$];
  int          last_settle_us = 0;
  int          failures = 0;
  int          burst_left = 1;
  int          inits_left = 6;

  logic [9:0]  ready_window  = '0;
  logic [31:0] ready_pattern = '1;

  char_lcd_bus_writer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reg_select_o     (reg_select_o),
    .read_write_o     (read_write_o),
    .bus_value_o      (bus_value_o),
    .lead_wait_us_o   (lead_wait_us_o),
    .settle_wait_us_o (settle_wait_us_o),
    .last_o           (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Stall the output on a rotating pattern, fully open one window in four
  always @(posedge clk_i) begin
    ready_window <= ready_window + 10'd1;
    if (ready_window == '0) begin
      ready_pattern <= $urandom;
    end
    out_ready_i <= (ready_window[9:8] == 2'd3) ? 1'b1 : ready_pattern[ready_window[4:0]];
  end

  // ------------------------------------------------------------------
  // Strobe prediction
  // ------------------------------------------------------------------
  function automatic void push_strobe(logic rs, logic [7:0] bus, logic [15:0] lead,
                                      logic [12:0] settle, logic final_strobe);
    strobe_t s;
    s.reg_select     = rs;
    s.read_write     = 1'b0;
    s.bus_value      = bus;
    s.lead_wait_us   = lead;
    s.settle_wait_us = settle;
    s.last           = final_strobe;
    pending_strobes.push_back(s);
    last_settle_us = int'(settle);
  endfunction

  // High nibble first on the narrow bus; clear and home stretch the tail wait
  function automatic void push_byte(logic rs, logic [7:0] b, logic final_strobe);
    logic [12:0] tail_settle;
    tail_settle = (b == INSTR_CLEAR || b == INSTR_HOME) ? SETTLE_CLEAR_US : SETTLE_US;
    if (byte_bus) begin
      push_strobe(rs, b, 16'd0, tail_settle, final_strobe);
    end else begin
      push_strobe(rs, {4'h0, b[7:4]}, 16'd0, SETTLE_US, 1'b0);
      push_strobe(rs, {4'h0, b[3:0]}, 16'd0, tail_settle, final_strobe);
    end
  endfunction

  function automatic void predict_strobes(cmd_e cmd, logic [7:0] val);
    logic [7:0] wake;
    case (cmd)
      CMD_DATA:  push_byte(1'b1, val, 1'b1);
      CMD_INSTR: push_byte(1'b0, val, 1'b1);
      CMD_INIT: begin
        wake = byte_bus ? WAKE_BYTE : WAKE_NIBBLE;
        push_strobe(1'b0, wake, POWER_UP_US, SETTLE_FIRST_US, 1'b0);
        push_strobe(1'b0, wake, 16'd0, SETTLE_SHORT_US, 1'b0);
        push_strobe(1'b0, wake, 16'd0, SETTLE_US, 1'b0);
        if (byte_bus) begin
          push_byte(1'b0, FUNC_SET_8BIT, 1'b0);
        end else begin
          push_strobe(1'b0, NIBBLE_SWITCH, 16'd0, SETTLE_US, 1'b0);
          push_byte(1'b0, FUNC_SET_4BIT, 1'b0);
        end
        push_byte(1'b0, DISPLAY_OFF, 1'b0);
        push_byte(1'b0, INSTR_CLEAR, 1'b0);
        push_byte(1'b0, ENTRY_MODE, 1'b0);
        push_byte(1'b0, DISPLAY_ON, 1'b1);
      end
      default: ;  // unused command: dropped without a strobe
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Record checking
  // ------------------------------------------------------------------
  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    strobe_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_strobes.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual bus 0x%0h settle %0d last %0d",
                 $time, bus_value_o, settle_wait_us_o, last_o);
        failures++;
      end else begin
        want = pending_strobes.pop_front();
        check_field("reg_select", 32'(want.reg_select), 32'(reg_select_o));
        check_field("read_write", 32'(want.read_write), 32'(read_write_o));
        check_field("bus_value", 32'(want.bus_value), 32'(bus_value_o));
        check_field("lead_wait_us", 32'(want.lead_wait_us), 32'(lead_wait_us_o));
        check_field("settle_wait_us", 32'(want.settle_wait_us), 32'(settle_wait_us_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------
  // Hold the request until taken, then pace the next one in bursts
  task automatic send_request(cmd_e cmd, logic [7:0] val);
    int gap;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_strobes(cmd, val);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 3000) : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drain all records, then let the last strobe's bus time run out
  task automatic wait_idle();
    int spins;
    int scale;
    spins = 0;
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
    end
    while (pending_strobes.size() != 0 && spins < IDLE_WAIT_LIMIT) begin
      @(posedge clk_i);
      spins++;
    end
    if (pending_strobes.size() != 0) begin
      $display("%0t: %0d expected records never arrived, first expected bus 0x%0h",
               $time, pending_strobes.size(), pending_strobes[0].bus_value);
      failures++;
      pending_strobes.delete();
    end
    scale = (clocks_cfg == '0) ? 1024 : int'(clocks_cfg);
    repeat ((1 + last_settle_us) * scale + 32) @(posedge clk_i);
  endtask

  task automatic write_setting(logic [1:0] idx, logic [9:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_BUS_MODE) begin
      byte_bus = data[0];
    end else if (idx == REG_CLOCKS_PER_US) begin
      clocks_cfg = data;
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Reset settings: nibble bus at the reset clock scaling
  task automatic test_reset_defaults();
    send_request(CMD_DATA, 8'h41);
  endtask

  task automatic test_nibble_bus();
    wait_idle();
    write_setting(REG_CLOCKS_PER_US, 10'd1);
    send_request(CMD_DATA, 8'h00);
    send_request(CMD_DATA, 8'hFF);
    send_request(CMD_INSTR, INSTR_CLEAR);
    send_request(CMD_INSTR, INSTR_HOME);
    // clear and home bytes stretch the wait even as characters
    send_request(CMD_DATA, INSTR_CLEAR);
    send_request(CMD_DATA, INSTR_HOME);
    send_request(CMD_INSTR, 8'h80);
    send_request(CMD_NONE, 8'hA5);
    send_request(CMD_INIT, 8'h00);
  endtask

  task automatic test_byte_bus();
    wait_idle();
    write_setting(REG_BUS_MODE, 10'd1);
    send_request(CMD_DATA, 8'h00);
    send_request(CMD_DATA, 8'hFF);
    send_request(CMD_INSTR, INSTR_CLEAR);
    send_request(CMD_DATA, INSTR_HOME);
    send_request(CMD_INSTR, 8'h03);
    send_request(CMD_NONE, 8'h5A);
    send_request(CMD_INIT, 8'hFF);
  endtask

  // Writes past the register list must leave the settings alone
  task automatic test_spare_registers();
    wait_idle();
    write_setting(REG_SPARE_LO, 10'h3FF);
    write_setting(REG_SPARE_HI, 10'h000);
    send_request(CMD_DATA, 8'h5A);
    wait_idle();
    // only bit 0 selects the bus width
    write_setting(REG_BUS_MODE, 10'h3FE);
    write_setting(REG_CLOCKS_PER_US, 10'd17);
    send_request(CMD_DATA, 8'hC3);
  endtask

  task automatic test_clock_extremes();
    wait_idle();
    write_setting(REG_BUS_MODE, 10'd1);
    write_setting(REG_CLOCKS_PER_US, 10'd1000);
    send_request(CMD_INSTR, 8'h38);
    wait_idle();
    // zero scaling is taken as given
    write_setting(REG_CLOCKS_PER_US, 10'd0);
    send_request(CMD_DATA, 8'h55);
  endtask

  task automatic run_random_phase(logic mode, logic [9:0] clocks, int count);
    int         roll;
    int         taken;
    cmd_e       cmd;
    logic [7:0] val;
    taken = 0;
    wait_idle();
    write_setting(REG_BUS_MODE, {9'd0, mode});
    write_setting(REG_CLOCKS_PER_US, clocks);
    while (taken < count) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0) begin
        val = $urandom_range(0, 1) ? INSTR_CLEAR : INSTR_HOME;
      end else begin
        val = 8'($urandom_range(0, 255));
      end
      if (roll < 45) begin
        cmd = CMD_DATA;
      end else if (roll < 88) begin
        cmd = CMD_INSTR;
      end else if (roll < 93) begin
        cmd = CMD_NONE;
      end else if (clocks == 10'd1 && inits_left > 0) begin
        cmd = CMD_INIT;
        inits_left--;
      end else begin
        cmd = CMD_INSTR;
      end
      send_request(cmd, val);
      if (cmd != CMD_NONE) begin
        taken++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(1'b0, 10'd1, 50);
    run_random_phase(1'b1, 10'd2, 50);
    run_random_phase(1'b1, 10'd1, 50);
    run_random_phase(1'b0, 10'd3, 50);
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_nibble_bus();
    test_byte_bus();
    test_spare_registers();
    test_clock_extremes();
    test_random_traffic();
    wait_idle();
    if (failures == 0) begin
      $display("** char_lcd_bus_writer_core: PASSED **");
    end else begin
      $display("** char_lcd_bus_writer_core: FAILED **");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #100000000;
    $display("** char_lcd_bus_writer_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
